// File: design/fpdpc_pkg.sv
// shared types, widths and constants for the filtered pd position control unit
package fpdpc_pkg;

  // field widths
  localparam int unsigned POS_W   = 15;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned ALPHA_W = 9;
  localparam int unsigned ERR_W   = 16;
  localparam int unsigned DIFF_W  = 17;
  localparam int unsigned PWR_W   = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned DATA_W  = 16;

  // serial multiplier sizing
  localparam int unsigned FILT_ACC_W = 26;
  localparam int unsigned PD_ACC_W   = 35;
  localparam int unsigned FILT_STEPS = ALPHA_W;
  localparam int unsigned PD_STEPS   = GAIN_W;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned ROUND_SH   = 6;
  localparam int unsigned Q_W        = PD_ACC_W - ROUND_SH;

  // filter weight of one in Q1.8
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

  // register reset values
  localparam logic [POS_W-1:0]   TARGET_RST = 15'd0;
  localparam logic [GAIN_W-1:0]  KP_RST     = 16'd128;
  localparam logic [GAIN_W-1:0]  KD_RST     = 16'd2560;
  localparam logic [ALPHA_W-1:0] ALPHA_RST  = 9'd26;
  localparam logic [POS_W-1:0]   MAXP_RST   = 15'd25600;
  localparam logic [POS_W-1:0]   TOL_RST    = 15'd64;

  // register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_TARGET = 3'd0,
    REG_KP     = 3'd1,
    REG_KD     = 3'd2,
    REG_ALPHA  = 3'd3,
    REG_MAXP   = 3'd4,
    REG_TOL    = 3'd5
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_FILT = 6'b000010,
    S_ERR  = 6'b000100,
    S_MULT = 6'b001000,
    S_RND  = 6'b010000,
    S_SAT  = 6'b100000
  } state_t;

  // control of a serial multiply-accumulate unit
  typedef struct packed {
    logic load;
    logic step;
  } mac_ctl_t;

endpackage

// File: design/fpdpc_serial_mac.sv
// bit-serial dual multiply-accumulate: one multiplier bit of each product per cycle while step is high
module fpdpc_serial_mac #(
  parameter int unsigned MUL_W = 16,
  parameter int unsigned ACC_W = 35
) (
  input  logic                    clk,
  input  fpdpc_pkg::mac_ctl_t     ctl,
  input  logic [ACC_W-1:0]        acc_init,
  input  logic [ACC_W-1:0]        mcand_a,
  input  logic [ACC_W-1:0]        mcand_b,
  input  logic [MUL_W-1:0]        mlier_a,
  input  logic [MUL_W-1:0]        mlier_b,
  output logic [ACC_W-1:0]        acc
);
  import fpdpc_pkg::*;

  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] mc_a_r;
  logic [ACC_W-1:0] mc_b_r;
  logic [MUL_W-1:0] ml_a_r;
  logic [MUL_W-1:0] ml_b_r;
  logic [ACC_W-1:0] part_a;
  logic [ACC_W-1:0] part_b;

  // partial products selected by the low multiplier bits
  assign part_a = ml_a_r[0] ? mc_a_r : '0;
  assign part_b = ml_b_r[0] ? mc_b_r : '0;

  // load operands, then shift multipliers right and multiplicands left
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc_r  <= acc_init;
      mc_a_r <= mcand_a;
      mc_b_r <= mcand_b;
      ml_a_r <= mlier_a;
      ml_b_r <= mlier_b;
    end else if (ctl.step) begin
      acc_r  <= acc_r + part_a + part_b;
      mc_a_r <= {mc_a_r[ACC_W-2:0], 1'b0};
      mc_b_r <= {mc_b_r[ACC_W-2:0], 1'b0};
      ml_a_r <= {1'b0, ml_a_r[MUL_W-1:1]};
      ml_b_r <= {1'b0, ml_b_r[MUL_W-1:1]};
    end
  end

  assign acc = acc_r;

endmodule

// File: design/filtered_pd_position_control_unit.sv
// PD position loop with a first-order low-pass filter on the measured angle
//
// One position word in, one drive word out. The sample is blended into the
// filtered angle (alpha in Q1.8), error = target - filtered is formed, and the
// drive kp*error + kd*(error - previous error) is rounded to Q8.8 percent and
// clamped to +/- max_power; at_target flags |error| < tolerance. tuser high on
// an input word clears the filter and previous error before the sample is used.
// Items are handled one at a time: a word passes through the accept, filter,
// error, PD, round and clamp steps before in_tready rises again and the result
// is offered. The filter and PD steps are long because the bit-serial
// multipliers take one bit of alpha and one bit of each gain per cycle. The
// clamp stage holds while an earlier result still waits unaccepted, so
// out_tready stalls keep the block in that stage. A finished result waits
// in the output register while the next word is already taken in.
module filtered_pd_position_control_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // input words
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [fpdpc_pkg::DATA_W-1:0]     in_tdata,   // [14:0] position_sample, [15] zero
  input  logic                             in_tuser,   // [0] command
  // result words
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [fpdpc_pkg::DATA_W-1:0]     out_tdata,  // [15:0] motor_power
  output logic                             out_tuser,  // [0] at_target
  // configuration writes
  input  logic                             cfg_we,
  input  logic [fpdpc_pkg::IDX_W-1:0]      cfg_index,
  input  logic [fpdpc_pkg::CFG_W-1:0]      cfg_wdata
);
  import fpdpc_pkg::*;

  // configuration registers
  logic [POS_W-1:0]   target_r;
  logic [GAIN_W-1:0]  kp_r;
  logic [GAIN_W-1:0]  kd_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [POS_W-1:0]   maxp_r;
  logic [POS_W-1:0]   tol_r;

  // loop state
  logic [POS_W-1:0]   filt_r;
  logic [ERR_W-1:0]   prev_r;

  // sequencing
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic               in_acc;
  logic               out_load;

  // per-item datapath
  logic               at_r;
  logic               neg_r;
  logic [Q_W-1:0]     q_r;
  logic               out_valid_r;
  logic [PWR_W-1:0]   out_pwr_r;
  logic               out_at_r;

  // filter unit wiring
  mac_ctl_t              fmac_ctl;
  logic [POS_W-1:0]      f_eff;
  logic [ERR_W-1:0]      sdiff;
  logic [FILT_ACC_W-1:0] fmac_init;
  logic [FILT_ACC_W-1:0] fmac_mcand;
  logic [ALPHA_W-1:0]    a_eff;
  logic [FILT_ACC_W-1:0] facc;

  // pd unit wiring
  mac_ctl_t              pmac_ctl;
  logic [POS_W-1:0]      f_new;
  logic [ERR_W-1:0]      err;
  logic [DIFF_W-1:0]     diff;
  logic [ERR_W-1:0]      err_mag;
  logic [PD_ACC_W-1:0]   pacc;
  logic [PD_ACC_W-1:0]   s_mag;
  logic [PD_ACC_W-1:0]   s_rnd;
  logic [POS_W-1:0]      lim;
  logic [PWR_W-1:0]      pwr;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == S_SAT) && (!out_valid_r || out_tready);

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RST;
      kp_r     <= KP_RST;
      kd_r     <= KD_RST;
      alpha_r  <= ALPHA_RST;
      maxp_r   <= MAXP_RST;
      tol_r    <= TOL_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_TARGET: target_r <= cfg_wdata[POS_W-1:0];
        REG_KP:     kp_r     <= cfg_wdata[GAIN_W-1:0];
        REG_KD:     kd_r     <= cfg_wdata[GAIN_W-1:0];
        REG_ALPHA:  alpha_r  <= cfg_wdata[ALPHA_W-1:0];
        REG_MAXP:   maxp_r   <= cfg_wdata[POS_W-1:0];
        REG_TOL:    tol_r    <= cfg_wdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // filter operands: 256*f + 128 + alpha*(sample - f)
  assign f_eff      = in_tuser ? '0 : filt_r;
  assign sdiff      = {1'b0, in_tdata[POS_W-1:0]} - {1'b0, f_eff};
  assign fmac_init  = {3'b000, f_eff, 8'h80};
  assign fmac_mcand = {{(FILT_ACC_W-ERR_W){sdiff[ERR_W-1]}}, sdiff};
  assign a_eff      = alpha_r[ALPHA_W-1] ? ALPHA_ONE : alpha_r;

  assign fmac_ctl.load = in_acc;
  assign fmac_ctl.step = (state_r == S_FILT);

  fpdpc_serial_mac #(
    .MUL_W (ALPHA_W),
    .ACC_W (FILT_ACC_W)
  ) u_filt_mac (
    .clk      (clk),
    .ctl      (fmac_ctl),
    .acc_init (fmac_init),
    .mcand_a  (fmac_mcand),
    .mcand_b  ('0),
    .mlier_a  (a_eff),
    .mlier_b  ('0),
    .acc      (facc)
  );

  // error, derivative difference and tolerance check
  assign f_new   = facc[POS_W+7:8];
  assign err     = {1'b0, target_r} - {1'b0, f_new};
  assign diff    = {err[ERR_W-1], err} - {prev_r[ERR_W-1], prev_r};
  assign err_mag = err[ERR_W-1] ? (ERR_W'(0) - err) : err;

  assign pmac_ctl.load = (state_r == S_ERR);
  assign pmac_ctl.step = (state_r == S_MULT);

  fpdpc_serial_mac #(
    .MUL_W (GAIN_W),
    .ACC_W (PD_ACC_W)
  ) u_pd_mac (
    .clk      (clk),
    .ctl      (pmac_ctl),
    .acc_init ('0),
    .mcand_a  ({{(PD_ACC_W-ERR_W){err[ERR_W-1]}}, err}),
    .mcand_b  ({{(PD_ACC_W-DIFF_W){diff[DIFF_W-1]}}, diff}),
    .mlier_a  (kp_r),
    .mlier_b  (kd_r),
    .acc      (pacc)
  );

  // round half away from zero, then clamp to the power limit
  assign s_mag = pacc[PD_ACC_W-1] ? (PD_ACC_W'(0) - pacc) : pacc;
  assign s_rnd = s_mag + PD_ACC_W'(32);
  assign lim   = (q_r > {{(Q_W-POS_W){1'b0}}, maxp_r}) ? maxp_r : q_r[POS_W-1:0];
  assign pwr   = neg_r ? (PWR_W'(0) - {1'b0, lim}) : {1'b0, lim};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_FILT;
      S_FILT: if (cnt_r == CNT_W'(FILT_STEPS - 1)) state_nxt = S_ERR;
      S_ERR:  state_nxt = S_MULT;
      S_MULT: if (cnt_r == CNT_W'(PD_STEPS - 1)) state_nxt = S_RND;
      S_RND:  state_nxt = S_SAT;
      S_SAT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_FILT) && (state_nxt == S_FILT)) begin
        cnt_r <= cnt_r + 1'b1;
      end else if ((state_r == S_MULT) && (state_nxt == S_MULT)) begin
        cnt_r <= cnt_r + 1'b1;
      end else begin
        cnt_r <= '0;
      end
    end
  end

  // filter and previous error state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= '0;
      prev_r <= '0;
    end else if (in_acc && in_tuser) begin
      filt_r <= '0;
      prev_r <= '0;
    end else if (state_r == S_ERR) begin
      filt_r <= f_new;
      prev_r <= err;
    end
  end

  // per-item result staging
  always_ff @(posedge clk) begin
    if (state_r == S_ERR) begin
      at_r <= (err_mag < {1'b0, tol_r});
    end
    if (state_r == S_RND) begin
      neg_r <= pacc[PD_ACC_W-1];
      q_r   <= s_rnd[PD_ACC_W-1:ROUND_SH];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pwr_r <= pwr;
      out_at_r  <= at_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pwr_r;
  assign out_tuser  = out_at_r;

`ifndef NO_ASSERTIONS
  // the blended position is a convex mix, so the filter sum never goes negative
  a_filt_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ERR) |-> !facc[FILT_ACC_W-1])
    else $error("filter accumulator negative");

  // rounding starts exactly after all gain bits have been consumed
  a_pd_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RND) |-> ($past(state_r, PD_STEPS + 1) == S_ERR))
    else $error("pd multiply did not take the expected number of cycles");

  // a held drive word stays within the power limit
  a_pwr_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (($signed(out_pwr_r) <= $signed({1'b0, maxp_r})) &&
                     ($signed(out_pwr_r) >= -$signed({1'b0, maxp_r}))))
    else $error("motor power outside the limit");
`endif

endmodule
